// ----- rtl/psp_pkg.sv -----
// Package for the parallel segment pair finder: sizes, fixed-point
// constants, CORDIC arctangent table, register indexes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package psp_pkg;

  localparam int MAX_SEGMENTS    = 16;
  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 13;

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int ANG_W  = 16;
  localparam int TOL_W  = 15;
  localparam int LIM_W  = 5;
  localparam int LIDX_W = 4;
  localparam int MASK_W = 16;

  // CORDIC datapath: coordinates scaled by 2^14, angle accumulator in Q30
  localparam int CORDIC_STEPS = ANGLE_FRAC_BITS + 3;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int PRE_SHIFT    = 14;
  localparam int XY_W         = COORD_BITS + PRE_SHIFT + 4;
  localparam int Z_W          = 35;
  localparam int RND_SHIFT    = 30 - ANGLE_FRAC_BITS;

  localparam logic [Z_W-1:0] PI_Q30 = Z_W'(64'd3373259426);
  localparam logic [Z_W-1:0] PI_RND = PI_Q30 + (Z_W'(1) << (RND_SHIFT - 1));
  localparam logic [ANG_W+1:0] PI_F = (ANG_W + 2)'(PI_RND >> RND_SHIFT);

  localparam int ATAN_DEPTH = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);

  localparam logic [29:0] ATAN_Q30 [0:ATAN_DEPTH-1] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021688,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 2'd1;

  localparam logic [TOL_W-1:0] TOL_RESET   = 15'd2458;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_WRITE,
    ST_ROW_LD,
    ST_ROW_CAP,
    ST_SWEEP,
    ST_EMIT
  } psp_state_t;

endpackage

// ----- rtl/psp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module psp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/parallel_segment_pair_finder_core.sv -----
// Top level of the parallel segment pair finder: CORDIC angle sequencer,
// angle store and pairwise compare. Depends on psp_pkg and psp_ram.
`timescale 1ns / 1ps

// Each input beat is one line segment. Up to min(line_limit, 16) segments per
// set are kept; their direction angle atan2(dy, dx) is found by a shared
// CORDIC stage run once per cycle for 16 iterations and written to a 16-entry
// angle RAM (signed, 13 fractional bits of radians). A segment with dy = 0
// skips the rotations. A kept segment is rotated (unless dy = 0) and then
// written; a dropped one is not stored. On the beat marked last_segment, the
// stored angles are walked through the single RAM read port: each row is
// loaded, captured, swept over the later segments and emitted (after any
// output stall) as one result beat with the row's index and a mask of the
// later segments parallel to it (|d| < tol or ||d| - pi| < tol, no 2*pi
// wrap). The last result carries last_result and empties the store. in_stall
// is low only while the sequencer is idle; a pending result may still sit in
// the output register then. Configuration writes are always ready.

module parallel_segment_pair_finder_core (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [psp_pkg::COORD_BITS-1:0] in_start_x,
  input  logic [psp_pkg::COORD_BITS-1:0] in_start_y,
  input  logic [psp_pkg::COORD_BITS-1:0] in_end_x,
  input  logic [psp_pkg::COORD_BITS-1:0] in_end_y,
  input  logic                           in_last_segment,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [psp_pkg::LIDX_W-1:0]     out_line_index,
  output logic [psp_pkg::MASK_W-1:0]     out_partner_mask,
  output logic                           out_last_result,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import psp_pkg::*;

  psp_state_t state_r, state_nxt;

  logic [TOL_W-1:0]  tol_r;
  logic [LIM_W-1:0]  limit_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  lim;
  logic              store_ok;
  logic              last_r;

  // CORDIC registers
  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]  z_r;
  logic [STEP_W-1:0]      step_r;

  // compare walk
  logic [CNT_W-1:0]       i_r, j_r;
  logic signed [ANG_W-1:0] ai_r;
  logic [MASK_W-1:0]      mask_r;

  // output register
  logic              out_valid_r;
  logic [LIDX_W-1:0] out_idx_r;
  logic [MASK_W-1:0] out_mask_r;
  logic              out_last_r;

  // RAM
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ANG_W-1:0]  ram_rdata;
  logic [ANG_W-1:0]  angle_q;

  // input deltas
  logic signed [COORD_BITS:0] dx, dy;
  logic signed [XY_W-1:0]     dx_w, dy_w;
  logic                       dy_zero;

  logic emit_go;
  logic row_last;
  logic par_hit;

  assign cfg_ready = 1'b1;

  assign lim      = (limit_r > LIM_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                    : CNT_W'(limit_r);
  assign store_ok = count_r < lim;

  assign dx      = $signed({1'b0, in_end_x}) - $signed({1'b0, in_start_x});
  assign dy      = $signed({1'b0, in_end_y}) - $signed({1'b0, in_start_y});
  assign dx_w    = XY_W'(dx);
  assign dy_w    = XY_W'(dy);
  assign dy_zero = (dy == '0);

  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign row_last = (i_r + CNT_W'(1)) == count_r;

  // rounding to the stored angle format
  logic signed [Z_W-1:0] z_rnd;
  assign z_rnd   = z_r + $signed(Z_W'(1) << (RND_SHIFT - 1));
  assign angle_q = ANG_W'(z_rnd >>> RND_SHIFT);

  // shared compare unit: a_i against a_j coming out of the RAM
  logic signed [ANG_W:0]   d_s;
  logic [ANG_W:0]          d_abs;
  logic signed [ANG_W+1:0] e_s;
  logic [ANG_W+1:0]        e_abs;
  always_comb begin
    d_s   = (ANG_W + 1)'(ai_r) - (ANG_W + 1)'($signed(ram_rdata));
    d_abs = d_s[ANG_W] ? (ANG_W + 1)'(-d_s) : (ANG_W + 1)'(d_s);
    e_s   = $signed({1'b0, d_abs}) - $signed(PI_F);
    e_abs = e_s[ANG_W+1] ? (ANG_W + 2)'(-e_s) : (ANG_W + 2)'(e_s);
    par_hit = ((ANG_W + 2)'(d_abs) < (ANG_W + 2)'(tol_r)) ||
              (e_abs < (ANG_W + 2)'(tol_r));
  end

  // shared CORDIC stage
  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  t_step;
  assign xs     = x_r >>> step_r;
  assign ys     = y_r >>> step_r;
  assign t_step = $signed(Z_W'(ATAN_Q30[ATAN_IDX_W'(step_r)]));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (store_ok) begin
            state_nxt = dy_zero ? ST_WRITE : ST_ROT;
          end else if (in_last_segment && count_r != '0) begin
            state_nxt = ST_ROW_LD;
          end
        end
      end
      ST_ROT: begin
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE:   state_nxt = last_r ? ST_ROW_LD : ST_IDLE;
      ST_ROW_LD:  state_nxt = ST_ROW_CAP;
      ST_ROW_CAP: state_nxt = row_last ? ST_EMIT : ST_SWEEP;
      ST_SWEEP: begin
        if ((j_r + CNT_W'(1)) == count_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = row_last ? ST_IDLE : ST_ROW_LD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_raddr = i_r[IDX_W-1:0];
    case (state_r)
      ST_IDLE:    in_stall  = 1'b0;
      ST_WRITE:   ram_we    = 1'b1;
      ST_ROW_LD:  ram_raddr = i_r[IDX_W-1:0];
      ST_ROW_CAP: ram_raddr = IDX_W'(i_r + CNT_W'(1));
      ST_SWEEP:   ram_raddr = IDX_W'(j_r + CNT_W'(1));
      default: begin
      end
    endcase
  end

  psp_ram #(
    .WIDTH (ANG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_angle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (angle_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tol_r       <= TOL_RESET;
      limit_r     <= LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ANGLE_TOL:  tol_r   <= cfg_data[TOL_W-1:0];
          REG_LINE_LIMIT: limit_r <= cfg_data[LIM_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == ST_WRITE) begin
        count_r <= count_r + CNT_W'(1);
      end else if (emit_go && row_last) begin
        count_r <= '0;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_r <= in_last_segment;
          step_r <= '0;
          i_r    <= '0;
          if (dy_zero) begin
            z_r <= dx[COORD_BITS] ? $signed(PI_Q30) : '0;
          end else if (dx[COORD_BITS]) begin
            x_r <= (-dx_w) <<< PRE_SHIFT;
            y_r <= (-dy_w) <<< PRE_SHIFT;
            z_r <= dy[COORD_BITS] ? -$signed(PI_Q30) : $signed(PI_Q30);
          end else begin
            x_r <= dx_w <<< PRE_SHIFT;
            y_r <= dy_w <<< PRE_SHIFT;
            z_r <= '0;
          end
        end
      end
      ST_ROT: begin
        if (!y_r[XY_W-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + t_step;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - t_step;
        end
        step_r <= step_r + STEP_W'(1);
      end
      ST_ROW_CAP: begin
        ai_r   <= $signed(ram_rdata);
        mask_r <= '0;
        j_r    <= i_r + CNT_W'(1);
      end
      ST_SWEEP: begin
        if (par_hit) begin
          mask_r[j_r[IDX_W-1:0]] <= 1'b1;
        end
        j_r <= j_r + CNT_W'(1);
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_idx_r  <= LIDX_W'(i_r);
          out_mask_r <= mask_r;
          out_last_r <= row_last;
          i_r        <= i_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_line_index   = out_idx_r;
  assign out_partner_mask = out_mask_r;
  assign out_last_result  = out_last_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SEGMENTS))
    else $error("stored count above store depth");

  a_write_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> count_r < lim)
    else $error("angle written beyond line limit");

  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> (j_r > i_r) && (j_r < count_r))
    else $error("pair walk out of order");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && row_last |=> count_r == '0 && out_valid && out_last_result)
    else $error("final result did not empty the store");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for parallel_segment_pair_finder_core: directed and random segment
// sets, predicted with a behavioral CORDIC angle model and a pairwise compare.
// Depends on psp_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import psp_pkg::*;

  localparam int     QUIET_LIMIT   = 4000;  // cycles with no beat on any port
  localparam int     SETTLE_CYCLES = 30;    // > occupancy of a kept segment
  localparam int     RANDOM_KEPT   = 370;
  localparam int     COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int     ROT_STEPS     = ANGLE_FRAC_BITS + 3;
  localparam int     TOL_FULL      = (1 << TOL_W) - 1;
  localparam int     TOL_HALF_TURN = 25736;
  localparam longint HALF_TURN_Q30 = 64'sd3373259426;

  // round(atan(2^-i) * 2^30)
  localparam longint ARCTAN_Q30 [0:15] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021688,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768
  };

  typedef struct {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic                  last_segment;
  } segment_t;

  typedef struct {
    logic [LIDX_W-1:0] line_index;
    logic [MASK_W-1:0] partner_mask;
    logic              last_result;
  } pair_result_t;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [COORD_BITS-1:0] in_start_x      = '0;
  logic [COORD_BITS-1:0] in_start_y      = '0;
  logic [COORD_BITS-1:0] in_end_x        = '0;
  logic [COORD_BITS-1:0] in_end_y        = '0;
  logic                  in_last_segment = 1'b0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [LIDX_W-1:0]     out_line_index;
  logic [MASK_W-1:0]     out_partner_mask;
  logic                  out_last_result;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = REG_ANGLE_TOL;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  // shadow registers and angle store of the predictor
  int           tol_setting   = TOL_RESET;
  int           limit_setting = LIMIT_RESET;
  int           line_angles [MAX_SEGMENTS];
  int           lines_held    = 0;
  int           lines_kept    = 0;
  pair_result_t pairs_due [$];
  pair_result_t next_due;

  int mismatches     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  parallel_segment_pair_finder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_last_segment  (in_last_segment),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_index   (out_line_index),
    .out_partner_mask (out_partner_mask),
    .out_last_result  (out_last_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Angle prediction
  // ---------------------------------------------------------------------------

  // Q30 radians to the stored format, round half up
  function automatic longint q30_round(input longint z);
    return (z + (longint'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
  endfunction

  // atan2(dy, dx) by CORDIC vectoring; horizontal segments skip the rotations
  function automatic int direction_angle(input int dx, input int dy);
    longint x, y, z, xs, ys;
    if (dy == 0)
      return (dx < 0) ? int'(q30_round(HALF_TURN_Q30)) : 0;
    if (dx < 0) begin
      // fold into the right half plane and start from +/- pi
      x = longint'(-dx) * 16384;
      y = longint'(-dy) * 16384;
      z = (dy >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
    end else begin
      x = longint'(dx) * 16384;
      y = longint'(dy) * 16384;
      z = 0;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q30[i];
      end
    end
    return int'(q30_round(z));
  endfunction

  // Store the segment's angle if there is room; on the last beat queue one result per
  // stored line with the mask of later parallel (or antiparallel) lines.
  task automatic predict_segment(input segment_t seg);
    int cap, d, e, half_turn;
    pair_result_t r;
    cap = (limit_setting < MAX_SEGMENTS) ? limit_setting : MAX_SEGMENTS;
    half_turn = int'(q30_round(HALF_TURN_Q30));
    if (lines_held < cap) begin
      line_angles[lines_held] = direction_angle(int'(seg.end_x) - int'(seg.start_x),
                                                int'(seg.end_y) - int'(seg.start_y));
      lines_held++;
      lines_kept++;
    end
    if (!seg.last_segment)
      return;
    for (int i = 0; i < lines_held; i++) begin
      r.line_index   = LIDX_W'(i);
      r.partner_mask = '0;
      for (int j = i + 1; j < lines_held; j++) begin
        d = line_angles[i] - line_angles[j];
        if (d < 0) d = -d;
        e = d - half_turn;   // no 2*pi wrap
        if (e < 0) e = -e;
        if (d < tol_setting || e < tol_setting)
          r.partner_mask[j] = 1'b1;
      end
      r.last_result = (i == lines_held - 1);
      pairs_due = {pairs_due, r};
    end
    lines_held = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Receiver backpressure; recv_stall_pct follows the current phase
  always @(posedge clk)
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);

  // One segment beat. in_valid stays high between back-to-back beats; it is only
  // lowered by an idle gap or by the callers that wait for the block to drain.
  task automatic send_segment(input segment_t seg);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_start_x      <= seg.start_x;
    in_start_y      <= seg.start_y;
    in_end_x        <= seg.end_x;
    in_end_y        <= seg.end_y;
    in_last_segment <= seg.last_segment;
    do @(posedge clk); while (in_stall);
    predict_segment(seg);
  endtask

  // Both registers, written only once the block has gone quiet
  task automatic program_registers(input int tol, input int lim);
    in_valid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ANGLE_TOL;
    cfg_data  <= CFG_DATA_W'(tol);
    do @(posedge clk); while (!cfg_ready);
    tol_setting = tol & TOL_FULL;
    cfg_index <= REG_LINE_LIMIT;
    cfg_data  <= CFG_DATA_W'(lim);
    do @(posedge clk); while (!cfg_ready);
    limit_setting = lim & ((1 << LIM_W) - 1);
    cfg_valid <= 1'b0;
  endtask

  function automatic segment_t make_segment(input int sx, input int sy, input int ex,
                                            input int ey, input bit last);
    segment_t s;
    s.start_x      = COORD_BITS'(sx);
    s.start_y      = COORD_BITS'(sy);
    s.end_x        = COORD_BITS'(ex);
    s.end_y        = COORD_BITS'(ey);
    s.last_segment = last;
    return s;
  endfunction

  function automatic int signed_rand(input int m);
    return int'($urandom_range(2 * m, 0)) - m;
  endfunction

  // Place a displacement at a random spot that keeps both endpoints on the grid
  function automatic segment_t place_segment(input int dx, input int dy, input bit last);
    int sx, sy;
    if (dx > COORD_MAX) dx = COORD_MAX;
    if (dx < -COORD_MAX) dx = -COORD_MAX;
    if (dy > COORD_MAX) dy = COORD_MAX;
    if (dy < -COORD_MAX) dy = -COORD_MAX;
    sx = (dx >= 0) ? int'($urandom_range(COORD_MAX - dx, 0)) : int'($urandom_range(COORD_MAX, -dx));
    sy = (dy >= 0) ? int'($urandom_range(COORD_MAX - dy, 0)) : int'($urandom_range(COORD_MAX, -dy));
    return make_segment(sx, sy, sx + dx, sy + dy, last);
  endfunction

  // Mostly lines near one of two set directions (either sense), plus axis-aligned,
  // degenerate and fully random segments
  function automatic segment_t random_segment(input int bx0, input int by0, input int bx1,
                                              input int by1, input bit last);
    int pick, sense;
    pick = $urandom_range(99);
    if (pick < 15)
      return make_segment($urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                          $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0), last);
    if (pick < 25) begin
      case ($urandom_range(3))
        0:       return place_segment(signed_rand(COORD_MAX), 0, last);
        1:       return place_segment(0, signed_rand(COORD_MAX), last);
        2:       return place_segment(0, 0, last);
        default: return place_segment(signed_rand(COORD_MAX), signed_rand(1), last);
      endcase
    end
    if (pick < 85) begin
      sense = $urandom_range(1) ? 1 : -1;
      if ($urandom_range(1))
        return place_segment(sense * bx0 + signed_rand(3), sense * by0 + signed_rand(3), last);
      return place_segment(sense * bx1 + signed_rand(3), sense * by1 + signed_rand(3), last);
    end
    return place_segment(signed_rand(COORD_MAX), signed_rand(COORD_MAX), last);
  endfunction

  function automatic int pick_tolerance();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 1;
      2:       return TOL_RESET;
      3:       return TOL_HALF_TURN;
      4:       return TOL_FULL;
      5:       return $urandom_range(TOL_FULL, 0);
      default: return $urandom_range(800, 0);
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 31;
      2:       return 17;
      3:       return 1;
      4:       return 16;
      5:       return 2;
      default: return $urandom_range(16, 1);
    endcase
  endfunction

  function automatic int pick_base(input int sel);
    case (sel)
      0:       return signed_rand(60);
      1:       return signed_rand(1500);
      default: return signed_rand(COORD_MAX);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pairs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: unexpected result beat index=%0d mask=%h last=%0b",
                   $realtime, out_line_index, out_partner_mask, out_last_result);
      end else begin
        next_due = pairs_due.pop_front();
        if (out_line_index !== next_due.line_index ||
            out_partner_mask !== next_due.partner_mask ||
            out_last_result !== next_due.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: expected index=%0d mask=%h last=%0b, got index=%0d mask=%h last=%0b",
                     $realtime, next_due.line_index, next_due.partner_mask,
                     next_due.last_result, out_line_index, out_partner_mask,
                     out_last_result);
        end
      end
    end
  end

  // Watchdog: a hung handshake anywhere ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Axis directions, diagonals, zero length, and a near +pi / near -pi pair that is
  // only parallel if the 2*pi wrap were applied (it is not)
  task automatic test_direction_extremes();
    program_registers(TOL_RESET, LIMIT_RESET);
    send_segment(make_segment(0, 0, COORD_MAX, COORD_MAX, 1'b0));
    send_segment(make_segment(COORD_MAX, COORD_MAX, 0, 0, 1'b0));
    send_segment(make_segment(0, 0, COORD_MAX, 0, 1'b0));
    send_segment(make_segment(COORD_MAX, 0, 0, 0, 1'b0));
    send_segment(make_segment(7, 7, 7, 7, 1'b0));
    send_segment(make_segment(0, 0, 0, COORD_MAX, 1'b0));
    send_segment(make_segment(0, COORD_MAX, 0, 0, 1'b0));
    send_segment(make_segment(0, COORD_MAX, COORD_MAX, 0, 1'b0));
    send_segment(make_segment(COORD_MAX, 0, 0, COORD_MAX, 1'b0));
    send_segment(make_segment(COORD_MAX, COORD_MAX - 1, 0, COORD_MAX, 1'b0));
    send_segment(make_segment(COORD_MAX, 1, 0, 0, 1'b0));
    send_segment(make_segment(1, 0, 0, COORD_MAX, 1'b1));
  endtask

  // Identical directions never pair up with zero tolerance
  task automatic test_zero_tolerance();
    program_registers(0, LIMIT_RESET);
    send_segment(make_segment(10, 10, 20, 20, 1'b0));
    send_segment(make_segment(100, 300, 110, 310, 1'b0));
    send_segment(make_segment(40, 40, 30, 30, 1'b1));
  endtask

  // Store full: extra segments dropped, last mark on a dropped one still closes the set
  task automatic test_store_overflow();
    program_registers(TOL_FULL, 2);
    send_segment(make_segment(0, 0, 100, 3, 1'b0));
    send_segment(make_segment(50, 50, 10, 48, 1'b0));
    send_segment(make_segment(0, 0, COORD_MAX, COORD_MAX, 1'b0));
    send_segment(make_segment(1, 2, 3, 4, 1'b1));
  endtask

  // Nothing kept, so the last mark closes an empty set with no results
  task automatic test_limit_zero();
    program_registers(TOL_RESET, 0);
    send_segment(make_segment(5, 9, 900, 17, 1'b0));
    send_segment(make_segment(COORD_MAX, 0, 0, COORD_MAX, 1'b1));
  endtask

  // A single line after the empty set: index 0, empty mask, last flag set
  task automatic test_single_line();
    program_registers(TOL_HALF_TURN, 1);
    send_segment(make_segment(COORD_MAX, COORD_MAX, 0, 0, 1'b0));
    send_segment(make_segment(0, 0, 3, 3, 1'b1));
  endtask

  task automatic test_random_sets();
    int goal, cap, set_len, bx0, by0, bx1, by1, span;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      goal = lines_kept + RANDOM_KEPT / 4;
      while (lines_kept < goal) begin
        if (limit_setting == 0 || $urandom_range(99) < 30)
          program_registers(pick_tolerance(), pick_limit());
        cap  = (limit_setting < MAX_SEGMENTS) ? limit_setting : MAX_SEGMENTS;
        span = $urandom_range(2, 0);
        bx0 = pick_base(span);
        by0 = pick_base(span);
        bx1 = pick_base(span);
        by1 = pick_base(span);
        // mostly sets that fit; some overflow the store
        if ($urandom_range(99) < 15)
          set_len = $urandom_range(cap + 4, cap + 1);
        else
          set_len = $urandom_range((cap > 0) ? cap : 1, 1);
        for (int k = 0; k < set_len; k++)
          send_segment(random_segment(bx0, by0, bx1, by1, k == set_len - 1));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_direction_extremes();
    test_zero_tolerance();
    test_store_overflow();
    test_limit_zero();
    test_single_line();
    test_random_sets();
    in_valid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- parallel_segment_pair_finder_core.f -----
rtl/psp_pkg.sv
rtl/psp_ram.sv
rtl/parallel_segment_pair_finder_core.sv
dv/testbench.sv
